// ===== hw/rtl/rfsp_pkg.sv =====
// Shared types and constants for the ranging frame stream parser.
`default_nettype none

package rfsp_pkg;

    localparam int FRAME_BYTES = 31;
    localparam int FILL_W      = 5;

    // byte offsets inside a frame
    localparam int POS_SEQ   = 2;
    localparam int POS_ADDR  = 3;
    localparam int POS_ANGLE = 5;
    localparam int POS_RANGE = 9;
    localparam int POS_CMD   = 13;
    localparam int POS_PATH  = 15;
    localparam int POS_LEVEL = 19;
    localparam int POS_AX    = 23;
    localparam int POS_AY    = 25;
    localparam int POS_AZ    = 27;
    localparam int POS_SUM   = 29;
    localparam int POS_FOOT  = 30;

    // result status codes
    localparam logic [2:0] ST_NONE     = 3'd0;
    localparam logic [2:0] ST_OK       = 3'd1;
    localparam logic [2:0] ST_BAD_LEN  = 3'd2;
    localparam logic [2:0] ST_BAD_HDR  = 3'd3;
    localparam logic [2:0] ST_BAD_FOOT = 3'd4;
    localparam logic [2:0] ST_BAD_SUM  = 3'd5;

    // configuration register indexes
    localparam logic [1:0] REG_HEADER = 2'd0;
    localparam logic [1:0] REG_LENGTH = 2'd1;
    localparam logic [1:0] REG_FOOTER = 2'd2;

    typedef struct packed {
        logic [7:0] header;
        logic [7:0] length;
        logic [7:0] footer;
    } cfg_t;

    // controller -> datapath
    typedef struct packed {
        logic load;   // latch the input beat
        logic step;   // run one parser step on the latched byte
        logic shift;  // one resync scan position
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic out_free;   // result register can take a new beat
        logic bad_frame;  // current step completes a failing frame
        logic sync_done;  // current scan position ends the resync
    } sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rfsp_ctrl.sv =====
// Controller state machine for the frame parser.
`default_nettype none

module rfsp_ctrl
    import rfsp_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire sts_t sts,
    output cmd_t      cmd
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_STEP   = 3'b010,
        S_RESYNC = 3'b100
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_STEP;
                end
            end
            S_STEP:
            begin
                // wait here while the previous result is still unclaimed
                if (sts.out_free)
                begin
                    cmd.step   = 1'b1;
                    state_next = sts.bad_frame ? S_RESYNC : S_IDLE;
                end
            end
            S_RESYNC:
            begin
                cmd.shift = 1'b1;
                if (sts.sync_done)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    a_bad_to_resync: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_STEP && sts.out_free && sts.bad_frame) |=> state_reg == S_RESYNC)
        else $error("bad frame did not start resync");

    a_resync_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RESYNC && !sts.sync_done) |=> state_reg == S_RESYNC)
        else $error("resync left early");

    a_load_to_step: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (state_reg == S_STEP && !in_ready))
        else $error("accepted beat not processed");

endmodule

`default_nettype wire

// ===== hw/rtl/rfsp_dpath.sv =====
// Datapath: byte store, fill count, frame checks, resync shifter, result register.
`default_nettype none

module rfsp_dpath
    import rfsp_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire cfg_t               cfg,
    input  wire cmd_t               cmd,
    output sts_t                    sts,
    input  wire logic [7:0]         byte_in,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [2:0]              status,
    output logic [7:0]              sequence_res,
    output logic [15:0]             tag_id,
    output logic signed [31:0]      angle,
    output logic [31:0]             range_cm,
    output logic [15:0]             command_word,
    output logic signed [31:0]      path_power,
    output logic signed [31:0]      receive_level,
    output logic signed [15:0]      accel_x,
    output logic signed [15:0]      accel_y,
    output logic signed [15:0]      accel_z
);

    logic [7:0]        store_reg [FRAME_BYTES];
    logic [7:0]        byte_reg;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic              out_valid_reg, out_valid_next;

    logic [2:0]        status_reg;
    logic [7:0]        seq_reg;
    logic [15:0]       tag_reg;
    logic [31:0]       angle_reg;
    logic [31:0]       range_reg;
    logic [15:0]       cmdw_reg;
    logic [31:0]       path_reg;
    logic [31:0]       level_reg;
    logic [15:0]       ax_reg;
    logic [15:0]       ay_reg;
    logic [15:0]       az_reg;

    logic [2:0]        res_status;
    logic              wr_en;
    logic [FILL_W-1:0] wr_idx;
    logic [FILL_W-1:0] step_fill;
    logic [FILL_W-1:0] shift_fill;
    logic              frame_ok;
    logic              bad_frame;
    logic              found;
    logic              last_pos;
    logic [7:0]        chk;

    // checksum over the payload bytes
    always_comb
    begin
        chk = 8'h00;
        for (int i = POS_SEQ; i < POS_SUM; i++)
        begin
            chk = chk ^ store_reg[i];
        end
    end

    // one parser step on the latched byte
    always_comb
    begin
        res_status = ST_NONE;
        wr_en      = 1'b0;
        wr_idx     = fill_reg;
        step_fill  = fill_reg;
        frame_ok   = 1'b0;
        bad_frame  = 1'b0;
        if (fill_reg == '0)
        begin
            if (byte_reg == cfg.header)
            begin
                wr_en     = 1'b1;
                wr_idx    = '0;
                step_fill = FILL_W'(1);
            end
        end
        else if (fill_reg == FILL_W'(1) && byte_reg != cfg.length)
        begin
            res_status = ST_BAD_LEN;
            wr_idx     = '0;
            if (byte_reg == cfg.header)
            begin
                wr_en     = 1'b1;
                step_fill = FILL_W'(1);
            end
            else
            begin
                step_fill = '0;
            end
        end
        else
        begin
            wr_en     = 1'b1;
            step_fill = FILL_W'(fill_reg + FILL_W'(1));
            if (fill_reg == FILL_W'(FRAME_BYTES - 1))
            begin
                // last byte is still in byte_reg
                if (store_reg[0] != cfg.header)
                begin
                    res_status = ST_BAD_HDR;
                end
                else if (store_reg[1] != cfg.length)
                begin
                    res_status = ST_BAD_LEN;
                end
                else if (byte_reg != cfg.footer)
                begin
                    res_status = ST_BAD_FOOT;
                end
                else if (store_reg[POS_SUM] != chk)
                begin
                    res_status = ST_BAD_SUM;
                end
                else
                begin
                    res_status = ST_OK;
                end
                if (res_status == ST_OK)
                begin
                    frame_ok  = 1'b1;
                    step_fill = '0;
                end
                else
                begin
                    bad_frame = 1'b1;
                end
            end
        end
    end

    // resync: each shift drops byte 0; stop when the new head is a header/length pair or at most two bytes are stored
    always_comb
    begin
        found      = (fill_reg >= FILL_W'(3)) && store_reg[1] == cfg.header
                     && store_reg[2] == cfg.length;
        last_pos   = (fill_reg <= FILL_W'(2));
        shift_fill = FILL_W'(fill_reg - FILL_W'(1));
        if (last_pos)
        begin
            shift_fill = (store_reg[1] == cfg.header) ? FILL_W'(1) : '0;
        end
    end

    assign sts.out_free  = !out_valid_reg || out_ready;
    assign sts.bad_frame = bad_frame;
    assign sts.sync_done = found || last_pos;

    always_comb
    begin
        fill_next = fill_reg;
        if (cmd.step)
        begin
            fill_next = step_fill;
        end
        else if (cmd.shift)
        begin
            fill_next = shift_fill;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.step)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // byte store, no reset
    always_ff @(posedge clk)
    begin
        if (cmd.shift)
        begin
            for (int k = 0; k < FRAME_BYTES - 1; k++)
            begin
                store_reg[k] <= store_reg[k + 1];
            end
        end
        else if (cmd.step && wr_en)
        begin
            store_reg[wr_idx] <= byte_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            byte_reg <= byte_in;
        end
    end

    // result register, fields zero unless the frame passed
    always_ff @(posedge clk)
    begin
        if (cmd.step)
        begin
            status_reg <= res_status;
            if (frame_ok)
            begin
                seq_reg   <= store_reg[POS_SEQ];
                tag_reg   <= {store_reg[POS_ADDR + 1], store_reg[POS_ADDR]};
                angle_reg <= {store_reg[POS_ANGLE + 3], store_reg[POS_ANGLE + 2],
                              store_reg[POS_ANGLE + 1], store_reg[POS_ANGLE]};
                range_reg <= {store_reg[POS_RANGE + 3], store_reg[POS_RANGE + 2],
                              store_reg[POS_RANGE + 1], store_reg[POS_RANGE]};
                cmdw_reg  <= {store_reg[POS_CMD + 1], store_reg[POS_CMD]};
                path_reg  <= {store_reg[POS_PATH + 3], store_reg[POS_PATH + 2],
                              store_reg[POS_PATH + 1], store_reg[POS_PATH]};
                level_reg <= {store_reg[POS_LEVEL + 3], store_reg[POS_LEVEL + 2],
                              store_reg[POS_LEVEL + 1], store_reg[POS_LEVEL]};
                ax_reg    <= {store_reg[POS_AX + 1], store_reg[POS_AX]};
                ay_reg    <= {store_reg[POS_AY + 1], store_reg[POS_AY]};
                az_reg    <= {store_reg[POS_AZ + 1], store_reg[POS_AZ]};
            end
            else
            begin
                seq_reg   <= '0;
                tag_reg   <= '0;
                angle_reg <= '0;
                range_reg <= '0;
                cmdw_reg  <= '0;
                path_reg  <= '0;
                level_reg <= '0;
                ax_reg    <= '0;
                ay_reg    <= '0;
                az_reg    <= '0;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign sequence_res  = seq_reg;
    assign tag_id        = tag_reg;
    assign angle         = $signed(angle_reg);
    assign range_cm      = range_reg;
    assign command_word  = cmdw_reg;
    assign path_power    = $signed(path_reg);
    assign receive_level = $signed(level_reg);
    assign accel_x       = $signed(ax_reg);
    assign accel_y       = $signed(ay_reg);
    assign accel_z       = $signed(az_reg);

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.shift |-> fill_reg < FILL_W'(FRAME_BYTES))
        else $error("full store outside resync");

    a_step_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |=> out_valid_reg)
        else $error("step produced no result");

    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg != ST_OK) |->
        (seq_reg == '0 && tag_reg == '0 && range_reg == '0 && az_reg == '0))
        else $error("fields set on a failed result");

endmodule

`default_nettype wire

// ===== hw/rtl/ranging_frame_stream_parser_core.sv =====
// Top level: APB register file plus parser controller and datapath.
// An accepted byte beat is latched into byte_reg and then stepped into the result
//   register; the step waits while the previous result beat is still waiting on the output.
// A new byte beat is taken only after the last one has been stepped; after a failed full
//   frame the resync scan shifts one stored byte position per cycle through the shifter.
// The input side takes the next beat while a finished result still waits on the output.
// Reset (rst_n low, asynchronous): config registers, fill count, state and
//   out_valid clear; the byte store is not cleared and is never read unwritten.
`default_nettype none

module ranging_frame_stream_parser_core
    import rfsp_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    // configuration
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [3:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // byte input
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic [7:0]    byte_in,
    // result output
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic [2:0]         status,
    output logic [7:0]         sequence_res,
    output logic [15:0]        tag_id,
    output logic signed [31:0] angle,
    output logic [31:0]        range_cm,
    output logic [15:0]        command_word,
    output logic signed [31:0] path_power,
    output logic signed [31:0] receive_level,
    output logic signed [15:0] accel_x,
    output logic signed [15:0] accel_y,
    output logic signed [15:0] accel_z
);

    logic [7:0] header_reg;
    logic [7:0] length_reg;
    logic [7:0] footer_reg;
    logic       wr_hit;
    logic [1:0] reg_idx;
    cfg_t       cfg;
    cmd_t       cmd;
    sts_t       sts;

    // Registers sit at byte offsets 0, 4, 8; word index is paddr[3:2].
    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_hit  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_reg <= '0;
            length_reg <= '0;
            footer_reg <= '0;
        end
        else if (wr_hit)
        begin
            // writes to the unused word are dropped
            case (reg_idx)
                REG_HEADER: header_reg <= pwdata[7:0];
                REG_LENGTH: length_reg <= pwdata[7:0];
                REG_FOOTER: footer_reg <= pwdata[7:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_HEADER: prdata = {24'h0, header_reg};
            REG_LENGTH: prdata = {24'h0, length_reg};
            REG_FOOTER: prdata = {24'h0, footer_reg};
            default:    prdata = '0;
        endcase
    end

    assign cfg.header = header_reg;
    assign cfg.length = length_reg;
    assign cfg.footer = footer_reg;

    // Controller sequences accept -> step -> optional resync scan.
    rfsp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Datapath holds the frame bytes and the registered result beat.
    rfsp_dpath u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .cmd           (cmd),
        .sts           (sts),
        .byte_in       (byte_in),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .sequence_res  (sequence_res),
        .tag_id        (tag_id),
        .angle         (angle),
        .range_cm      (range_cm),
        .command_word  (command_word),
        .path_power    (path_power),
        .receive_level (receive_level),
        .accel_x       (accel_x),
        .accel_y       (accel_y),
        .accel_z       (accel_z)
    );

endmodule

`default_nettype wire
